[rtl/core/gtc_pkg.sv]
// gtc_pkg: types, constants and record codes of the greedy triangle clusterer
// used by gtc_ctrl and greedy_triangle_clusterer_core; depends on nothing
`timescale 1ns / 1ps

package gtc_pkg;

  localparam int CNT_W        = 9;
  localparam int MAX_VERT_DEF = 256;
  localparam int TRI_CAP      = 256;
  localparam int VLIM_MIN     = 3;
  localparam int TLIM_MIN     = 1;
  localparam logic [CNT_W-1:0] VLIM_RESET = 9'd64;
  localparam logic [CNT_W-1:0] TLIM_RESET = 9'd124;

  localparam logic [1:0] REG_VERTEX_LIMIT   = 2'd0;
  localparam logic [1:0] REG_TRIANGLE_LIMIT = 2'd1;

  localparam logic [1:0] KIND_SUMMARY  = 2'd0;
  localparam logic [1:0] KIND_VERTEX   = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SUMQ,
    ST_OPEN,
    ST_VA,
    ST_VB,
    ST_VC,
    ST_TRI,
    ST_SUME
  } state_t;

  typedef struct packed {
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
    logic [31:0] boundary_tag;
    logic [63:0] lod_key;
    logic [31:0] primitive_id;
    logic [30:0] err_position;
    logic [30:0] err_displacement;
    logic [30:0] err_normal;
    logic [29:0] err_opacity;
    logic [30:0] err_spectral;
    logic        end_of_mesh;
  } tri_t;

  typedef struct packed {
    logic        last_of_run;
    logic [1:0]  record_kind;
    logic [31:0] index_value;
    logic [8:0]  slot_a;
    logic [8:0]  slot_b;
    logic [7:0]  slot_c;
    logic [30:0] max_position;
    logic [30:0] max_displacement;
    logic [30:0] max_normal;
    logic [29:0] max_opacity;
    logic [30:0] max_spectral;
  } rec_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] vcount;
  } status_t;

endpackage

[rtl/core/gtc_vlist.sv]
// gtc_vlist: vertex list of the open cluster, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module gtc_vlist #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   q_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

endmodule

[rtl/core/gtc_ctrl.sv]
// gtc_ctrl: sequencer, cluster state and the shared vertex compare unit
// depends on gtc_pkg; drives the gtc_vlist ports
`timescale 1ns / 1ps

module gtc_ctrl #(
  parameter int MAX_CLUSTER_VERTICES = gtc_pkg::MAX_VERT_DEF,
  parameter int AW = $clog2(MAX_CLUSTER_VERTICES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  gtc_pkg::tri_t            item,
  input  logic [gtc_pkg::CNT_W-1:0] vlim_cfg,
  input  logic [gtc_pkg::CNT_W-1:0] tlim_cfg,
  input  logic                     slot_free,
  output logic                     emit,
  output gtc_pkg::rec_t            rec,
  output gtc_pkg::status_t         sts,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [31:0]              mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [31:0]              mem_q
);

  import gtc_pkg::*;

  localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_CLUSTER_VERTICES);
  localparam logic [CNT_W-1:0] TCAP = CNT_W'(TRI_CAP);
  localparam logic [CNT_W-1:0] VMIN = CNT_W'(VLIM_MIN);
  localparam logic [CNT_W-1:0] TMIN = CNT_W'(TLIM_MIN);

  state_t state_r, state_nxt;
  tri_t   tri_r, tri_nxt;
  logic [CNT_W-1:0] vcount_r, vcount_nxt, tcount_r, tcount_nxt, scan_r, scan_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt, ic_r, ic_nxt;
  logic [CNT_W-1:0] la_r, la_nxt, lb_r, lb_nxt, lc_r, lc_nxt;
  logic cmp_v_r, cmp_v_nxt, fa_r, fa_nxt, fb_r, fb_nxt, fc_r, fc_nxt;
  logic open_r, open_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [63:0] key_r, key_nxt;
  logic [30:0] mp_r, mp_nxt, md_r, md_nxt, mn_r, mn_nxt, ms_r, ms_nxt;
  logic [29:0] mo_r, mo_nxt;

  logic [CNT_W-1:0] vlim_c, tlim_c;
  logic new_a, new_b, new_c, room, scan_more, close;
  logic [1:0] added;

  always_comb begin
    vlim_c = vlim_cfg;
    if (vlim_cfg < VMIN) vlim_c = VMIN;
    else if (vlim_cfg > MAXV) vlim_c = MAXV;
    tlim_c = tlim_cfg;
    if (tlim_cfg < TMIN) tlim_c = TMIN;
    else if (tlim_cfg > TCAP) tlim_c = TCAP;
  end

  assign new_a     = !fa_r;
  assign new_b     = (tri_r.vertex_b != tri_r.vertex_a) && !fb_r;
  assign new_c     = (tri_r.vertex_c != tri_r.vertex_a) &&
                     (tri_r.vertex_c != tri_r.vertex_b) && !fc_r;
  assign added     = 2'(new_a) + 2'(new_b) + 2'(new_c);
  assign room      = vcount_r < MAXV;
  assign scan_more = scan_r < vcount_r;
  assign close     = open_r && ((tri_r.boundary_tag != tag_r) || (tri_r.lod_key != key_r) ||
                     (tcount_r >= tlim_c) ||
                     (({1'b0, vcount_r} + 10'(added)) > {1'b0, vlim_c}));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (!scan_more && !cmp_v_r) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = close ? ST_SUMQ : ST_OPEN;
      ST_SUMQ:  if (slot_free) state_nxt = ST_OPEN;
      ST_OPEN:  state_nxt = ST_VA;
      ST_VA:    if (!(new_a && room) || slot_free) state_nxt = ST_VB;
      ST_VB:    if (!(new_b && room) || slot_free) state_nxt = ST_VC;
      ST_VC:    if (!(new_c && room) || slot_free) state_nxt = ST_TRI;
      ST_TRI:   if (slot_free) state_nxt = tri_r.end_of_mesh ? ST_SUME : ST_IDLE;
      ST_SUME:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit      = 1'b0;
    rec       = '0;
    mem_we    = 1'b0;
    mem_waddr = vcount_r[AW-1:0];
    mem_wdata = tri_r.vertex_a;
    mem_re    = 1'b0;
    mem_raddr = scan_r[AW-1:0];
    unique case (state_r)
      ST_SCAN: mem_re = scan_more;
      ST_SUMQ, ST_SUME: begin
        emit                 = slot_free;
        rec.record_kind      = KIND_SUMMARY;
        rec.last_of_run      = (state_r == ST_SUME);
        rec.slot_a           = vcount_r;
        rec.slot_b           = tcount_r;
        rec.max_position     = mp_r;
        rec.max_displacement = md_r;
        rec.max_normal       = mn_r;
        rec.max_opacity      = mo_r;
        rec.max_spectral     = ms_r;
      end
      ST_VA, ST_VB, ST_VC: begin
        rec.record_kind = KIND_VERTEX;
        if (state_r == ST_VA) begin
          emit      = new_a && room && slot_free;
          mem_wdata = tri_r.vertex_a;
        end else if (state_r == ST_VB) begin
          emit      = new_b && room && slot_free;
          mem_wdata = tri_r.vertex_b;
        end else begin
          emit      = new_c && room && slot_free;
          mem_wdata = tri_r.vertex_c;
        end
        mem_we          = emit;
        rec.index_value = mem_wdata;
      end
      ST_TRI: begin
        emit            = slot_free;
        rec.record_kind = KIND_TRIANGLE;
        rec.last_of_run = !tri_r.end_of_mesh;
        rec.index_value = tri_r.primitive_id;
        rec.slot_a      = la_r;
        rec.slot_b      = lb_r;
        rec.slot_c      = lc_r[7:0];
      end
      default: ;
    endcase
  end

  // cluster state and search registers
  always_comb begin
    tri_nxt = tri_r;  vcount_nxt = vcount_r;  tcount_nxt = tcount_r;
    scan_nxt = scan_r;  cmp_v_nxt = 1'b0;  cmp_idx_nxt = scan_r;
    fa_nxt = fa_r;  fb_nxt = fb_r;  fc_nxt = fc_r;
    ia_nxt = ia_r;  ib_nxt = ib_r;  ic_nxt = ic_r;
    la_nxt = la_r;  lb_nxt = lb_r;  lc_nxt = lc_r;
    open_nxt = open_r;  tag_nxt = tag_r;  key_nxt = key_r;
    mp_nxt = mp_r;  md_nxt = md_r;  mn_nxt = mn_r;  mo_nxt = mo_r;  ms_nxt = ms_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tri_nxt  = item;
          scan_nxt = '0;
          fa_nxt   = 1'b0;
          fb_nxt   = 1'b0;
          fc_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          scan_nxt  = scan_r + 1'b1;
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r) begin
          if (mem_q == tri_r.vertex_a) begin fa_nxt = 1'b1; ia_nxt = cmp_idx_r; end
          if (mem_q == tri_r.vertex_b) begin fb_nxt = 1'b1; ib_nxt = cmp_idx_r; end
          if (mem_q == tri_r.vertex_c) begin fc_nxt = 1'b1; ic_nxt = cmp_idx_r; end
        end
      end
      ST_SUMQ: begin
        if (slot_free) begin
          open_nxt   = 1'b0;
          vcount_nxt = '0;
          tcount_nxt = '0;
          fa_nxt     = 1'b0;
          fb_nxt     = 1'b0;
          fc_nxt     = 1'b0;
        end
      end
      ST_OPEN: begin
        if (!open_r) begin
          open_nxt   = 1'b1;
          tag_nxt    = tri_r.boundary_tag;
          key_nxt    = tri_r.lod_key;
          vcount_nxt = '0;
          tcount_nxt = '0;
          mp_nxt = tri_r.err_position;
          md_nxt = tri_r.err_displacement;
          mn_nxt = tri_r.err_normal;
          mo_nxt = tri_r.err_opacity;
          ms_nxt = tri_r.err_spectral;
        end else begin
          if (tri_r.err_position > mp_r)     mp_nxt = tri_r.err_position;
          if (tri_r.err_displacement > md_r) md_nxt = tri_r.err_displacement;
          if (tri_r.err_normal > mn_r)       mn_nxt = tri_r.err_normal;
          if (tri_r.err_opacity > mo_r)      mo_nxt = tri_r.err_opacity;
          if (tri_r.err_spectral > ms_r)     ms_nxt = tri_r.err_spectral;
        end
      end
      ST_VA: begin
        if (!new_a) la_nxt = ia_r;
        else if (!room) la_nxt = '0;
        else if (slot_free) begin
          la_nxt     = vcount_r;
          vcount_nxt = vcount_r + 1'b1;
        end
      end
      ST_VB: begin
        if (tri_r.vertex_b == tri_r.vertex_a) lb_nxt = la_r;
        else if (fb_r) lb_nxt = ib_r;
        else if (!room) lb_nxt = '0;
        else if (slot_free) begin
          lb_nxt     = vcount_r;
          vcount_nxt = vcount_r + 1'b1;
        end
      end
      ST_VC: begin
        if (tri_r.vertex_c == tri_r.vertex_a) lc_nxt = la_r;
        else if (tri_r.vertex_c == tri_r.vertex_b) lc_nxt = lb_r;
        else if (fc_r) lc_nxt = ic_r;
        else if (!room) lc_nxt = '0;
        else if (slot_free) begin
          lc_nxt     = vcount_r;
          vcount_nxt = vcount_r + 1'b1;
        end
      end
      ST_TRI: begin
        if (slot_free && tcount_r < TCAP) tcount_nxt = tcount_r + 1'b1;
      end
      ST_SUME: begin
        if (slot_free) begin
          open_nxt   = 1'b0;
          vcount_nxt = '0;
          tcount_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
      tcount_r <= '0;
      open_r   <= 1'b0;
      tag_r    <= '0;
      key_r    <= '0;
      mp_r     <= '0;
      md_r     <= '0;
      mn_r     <= '0;
      mo_r     <= '0;
      ms_r     <= '0;
      cmp_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      tcount_r <= tcount_nxt;
      open_r   <= open_nxt;
      tag_r    <= tag_nxt;
      key_r    <= key_nxt;
      mp_r     <= mp_nxt;
      md_r     <= md_nxt;
      mn_r     <= mn_nxt;
      mo_r     <= mo_nxt;
      ms_r     <= ms_nxt;
      cmp_v_r  <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri_r     <= tri_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    fa_r      <= fa_nxt;
    fb_r      <= fb_nxt;
    fc_r      <= fc_nxt;
    ia_r      <= ia_nxt;
    ib_r      <= ib_nxt;
    ic_r      <= ic_nxt;
    la_r      <= la_nxt;
    lb_r      <= lb_nxt;
    lc_r      <= lc_nxt;
  end

  assign sts.idle   = (state_r == ST_IDLE);
  assign sts.vcount = vcount_r;

endmodule

[rtl/core/greedy_triangle_clusterer_core.sv]
// greedy_triangle_clusterer_core: top level, config registers and output word register
// depends on gtc_pkg, gtc_vlist and gtc_ctrl
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | one triangle word
//   out     | output    | out_valid/out_stall| one record word (summary, vertex, triangle)
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// a triangle passes IDLE, SCAN over every cluster vertex, CHECK, OPEN, VA, VB, VC and TRI,
// plus SUMQ or SUME per summary word, and waits while the output register is stalled
// the vertex list is scanned one entry per cycle through its single read port
// reset (rst_n low, synchronous) empties the cluster and loads limits 64 and 124
// a stalled output holds the sequencer; in_stall is high until the triangle is done
`timescale 1ns / 1ps

module greedy_triangle_clusterer_core #(
  parameter int MAX_CLUSTER_VERTICES = gtc_pkg::MAX_VERT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_vertex_a,
  input  logic [31:0] in_vertex_b,
  input  logic [31:0] in_vertex_c,
  input  logic [31:0] in_boundary_tag,
  input  logic [63:0] in_lod_key,
  input  logic [31:0] in_primitive_id,
  input  logic [30:0] in_err_position,
  input  logic [30:0] in_err_displacement,
  input  logic [30:0] in_err_normal,
  input  logic [29:0] in_err_opacity,
  input  logic [30:0] in_err_spectral,
  input  logic        in_end_of_mesh,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_last_of_run,
  output logic [1:0]  out_record_kind,
  output logic [31:0] out_index_value,
  output logic [8:0]  out_slot_a,
  output logic [8:0]  out_slot_b,
  output logic [7:0]  out_slot_c,
  output logic [30:0] out_max_position,
  output logic [30:0] out_max_displacement,
  output logic [30:0] out_max_normal,
  output logic [29:0] out_max_opacity,
  output logic [30:0] out_max_spectral,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  import gtc_pkg::*;

  localparam int AW = $clog2(MAX_CLUSTER_VERTICES);

  logic [CNT_W-1:0] vlim_r, tlim_r;
  logic    out_valid_r;
  rec_t    out_r;
  tri_t    item;
  rec_t    ctl_rec;
  status_t sts;
  logic    ctl_emit, slot_free;
  logic    mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_q;

  assign item = '{vertex_a: in_vertex_a, vertex_b: in_vertex_b, vertex_c: in_vertex_c,
                  boundary_tag: in_boundary_tag, lod_key: in_lod_key,
                  primitive_id: in_primitive_id, err_position: in_err_position,
                  err_displacement: in_err_displacement, err_normal: in_err_normal,
                  err_opacity: in_err_opacity, err_spectral: in_err_spectral,
                  end_of_mesh: in_end_of_mesh};

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !sts.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r <= VLIM_RESET;
      tlim_r <= TLIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VERTEX_LIMIT:   vlim_r <= cfg_data;
        REG_TRIANGLE_LIMIT: tlim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_emit) begin
      out_r <= ctl_rec;
    end
  end

  gtc_vlist #(
    .DEPTH (MAX_CLUSTER_VERTICES),
    .AW    (AW)
  ) u_vlist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .q_r   (mem_q)
  );

  gtc_ctrl #(
    .MAX_CLUSTER_VERTICES (MAX_CLUSTER_VERTICES),
    .AW                   (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .item      (item),
    .vlim_cfg  (vlim_r),
    .tlim_cfg  (tlim_r),
    .slot_free (slot_free),
    .emit      (ctl_emit),
    .rec       (ctl_rec),
    .sts       (sts),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_q     (mem_q)
  );

  assign out_valid            = out_valid_r;
  assign out_last_of_run      = out_r.last_of_run;
  assign out_record_kind      = out_r.record_kind;
  assign out_index_value      = out_r.index_value;
  assign out_slot_a           = out_r.slot_a;
  assign out_slot_b           = out_r.slot_b;
  assign out_slot_c           = out_r.slot_c;
  assign out_max_position     = out_r.max_position;
  assign out_max_displacement = out_r.max_displacement;
  assign out_max_normal       = out_r.max_normal;
  assign out_max_opacity      = out_r.max_opacity;
  assign out_max_spectral     = out_r.max_spectral;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_emit |-> (!out_valid_r || !out_stall))
    else $error("record emitted into a full output register");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !sts.idle)
    else $error("sequencer idle right after accepting a triangle");

  a_vcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sts.vcount <= CNT_W'(MAX_CLUSTER_VERTICES))
    else $error("cluster vertex count past capacity");

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench of greedy_triangle_clusterer_core
// drives triangle words from a directed table then random meshes, predicts the records
// depends on gtc_pkg and the rtl under rtl/core
`timescale 1ns / 1ps

module tb_top;
  import gtc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tri_t        tri_w = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wire rec_t   got;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_VERTEX_LIMIT;
  logic [8:0]  cfg_data = '0;

  greedy_triangle_clusterer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a(tri_w.vertex_a), .in_vertex_b(tri_w.vertex_b),
    .in_vertex_c(tri_w.vertex_c), .in_boundary_tag(tri_w.boundary_tag),
    .in_lod_key(tri_w.lod_key), .in_primitive_id(tri_w.primitive_id),
    .in_err_position(tri_w.err_position), .in_err_displacement(tri_w.err_displacement),
    .in_err_normal(tri_w.err_normal), .in_err_opacity(tri_w.err_opacity),
    .in_err_spectral(tri_w.err_spectral), .in_end_of_mesh(tri_w.end_of_mesh),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_last_of_run(got.last_of_run), .out_record_kind(got.record_kind),
    .out_index_value(got.index_value), .out_slot_a(got.slot_a),
    .out_slot_b(got.slot_b), .out_slot_c(got.slot_c),
    .out_max_position(got.max_position), .out_max_displacement(got.max_displacement),
    .out_max_normal(got.max_normal), .out_max_opacity(got.max_opacity),
    .out_max_spectral(got.max_spectral),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cluster model
  logic [31:0] m_verts [0:255];
  int unsigned m_vcount, m_tcount;
  bit          m_open;
  logic [31:0] m_tag;
  logic [63:0] m_key;
  logic [30:0] m_max [0:4];
  logic [8:0]  m_vlim = VLIM_RESET, m_tlim = TLIM_RESET;
  rec_t        records_due [$];
  int          fails = 0, n_words = 0, n_recs = 0, n_summaries = 0;
  bit          hold_off = 1'b0;
  logic [8:0]  vl [0:5] = '{9'd3, 9'd0, 9'd511, 9'd8, 9'd256, 9'd64};
  logic [8:0]  tl [0:5] = '{9'd1, 9'd0, 9'd511, 9'd4, 9'd256, 9'd124};

  function automatic void queue_record(rec_t r);
    records_due = {records_due, r};
  endfunction

  function automatic int vert_slot(logic [31:0] v);
    for (int i = 0; i < m_vcount; i++)
      if (m_verts[i] == v) return i;
    return -1;
  endfunction

  function automatic void push_summary();
    rec_t r;
    r = '0;
    r.record_kind = KIND_SUMMARY;
    r.slot_a = 9'(m_vcount);
    r.slot_b = 9'(m_tcount);
    r.max_position = m_max[0];
    r.max_displacement = m_max[1];
    r.max_normal = m_max[2];
    r.max_opacity = m_max[3][29:0];
    r.max_spectral = m_max[4];
    queue_record(r);
    n_summaries++;
    m_open = 0;
    m_vcount = 0;
    m_tcount = 0;
  endfunction

  function automatic int place_vertex(logic [31:0] v);
    int f;
    rec_t r;
    f = vert_slot(v);
    if (f >= 0) return f;
    if (m_vcount >= 256) return 0;
    m_verts[m_vcount] = v;
    r = '0;
    r.record_kind = KIND_VERTEX;
    r.index_value = v;
    queue_record(r);
    m_vcount++;
    return m_vcount - 1;
  endfunction

  function automatic void cluster_triangle(tri_t t);
    int unsigned vl, tl, added, first;
    logic [30:0] e [0:4];
    int la, lb, lc;
    rec_t r;
    first = records_due.size();
    vl = m_vlim < 3 ? 3 : m_vlim;
    if (vl > 256) vl = 256;
    tl = m_tlim < 1 ? 1 : m_tlim;
    if (tl > 256) tl = 256;
    e[0] = t.err_position; e[1] = t.err_displacement; e[2] = t.err_normal;
    e[3] = {1'b0, t.err_opacity}; e[4] = t.err_spectral;
    if (m_open) begin
      added = (vert_slot(t.vertex_a) < 0)
            + (t.vertex_b != t.vertex_a && vert_slot(t.vertex_b) < 0)
            + (t.vertex_c != t.vertex_a && t.vertex_c != t.vertex_b
               && vert_slot(t.vertex_c) < 0);
      if (t.boundary_tag != m_tag || t.lod_key != m_key || m_tcount >= tl
          || m_vcount + added > vl)
        push_summary();
    end
    if (!m_open) begin
      m_open = 1;
      m_tag = t.boundary_tag;
      m_key = t.lod_key;
      for (int i = 0; i < 5; i++) m_max[i] = e[i];
    end else begin
      for (int i = 0; i < 5; i++) if (e[i] > m_max[i]) m_max[i] = e[i];
    end
    la = place_vertex(t.vertex_a);
    lb = place_vertex(t.vertex_b);
    lc = place_vertex(t.vertex_c);
    if (m_tcount < 256) m_tcount++;
    r = '0;
    r.record_kind = KIND_TRIANGLE;
    r.index_value = t.primitive_id;
    r.slot_a = 9'(la);
    r.slot_b = 9'(lb);
    r.slot_c = lc[7:0];
    queue_record(r);
    if (t.end_of_mesh) push_summary();
    records_due[records_due.size() - 1].last_of_run = 1'b1;
    if (records_due.size() == first) $error("no record predicted");
  endfunction

  // output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_recs++;
      if (records_due.size() == 0) begin
        $error("unexpected record kind=%0d", got.record_kind);
        fails++;
      end else begin
        rec_t x;
        x = records_due.pop_front();
        if (got !== x) begin
          fails++;
          if (got.last_of_run !== x.last_of_run)
            $error("last_of_run exp %0h got %0h", x.last_of_run, got.last_of_run);
          if (got.record_kind !== x.record_kind)
            $error("record_kind exp %0h got %0h", x.record_kind, got.record_kind);
          if (got.index_value !== x.index_value)
            $error("index_value exp %0h got %0h", x.index_value, got.index_value);
          if (got.slot_a !== x.slot_a) $error("slot_a exp %0h got %0h", x.slot_a, got.slot_a);
          if (got.slot_b !== x.slot_b) $error("slot_b exp %0h got %0h", x.slot_b, got.slot_b);
          if (got.slot_c !== x.slot_c) $error("slot_c exp %0h got %0h", x.slot_c, got.slot_c);
          if (got.max_position !== x.max_position)
            $error("max_position exp %0h got %0h", x.max_position, got.max_position);
          if (got.max_displacement !== x.max_displacement)
            $error("max_displacement exp %0h got %0h", x.max_displacement,
                   got.max_displacement);
          if (got.max_normal !== x.max_normal)
            $error("max_normal exp %0h got %0h", x.max_normal, got.max_normal);
          if (got.max_opacity !== x.max_opacity)
            $error("max_opacity exp %0h got %0h", x.max_opacity, got.max_opacity);
          if (got.max_spectral !== x.max_spectral)
            $error("max_spectral exp %0h got %0h", x.max_spectral, got.max_spectral);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int unsigned ph;
    ph = $urandom_range(0, 99);
    if (hold_off) out_stall <= 1'b1;
    else if (ph < 25) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) == 0);
  end

  // directed table: every row is checked against the predictor; the first row also checks the prediction
  typedef struct {
    logic [31:0] a, b, c, tag;
    logic [63:0] key;
    logic [31:0] prim;
    logic [30:0] e0, e1, e2, e4;
    logic [29:0] e3;
    bit          eom;
  } row_t;

  row_t rows [] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0, 32'h0, 31'h0, 31'h0, 31'h0, 31'h0, 30'h0, 1},
    '{32'hffffffff, 32'h1, 32'h2, 32'hffffffff, 64'hffffffffffffffff, 32'hffffffff,
      31'h7f7fffff, 31'h7f7fffff, 31'h40490fdb, 31'h7f7fffff, 30'h3f800000, 0},
    '{32'h1, 32'h2, 32'h3, 32'hffffffff, 64'hffffffffffffffff, 32'h5,
      31'h1, 31'h2, 31'h3, 31'h4, 30'h5, 0},
    '{32'h3, 32'h3, 32'h4, 32'hffffffff, 64'hffffffffffffffff, 32'h6,
      31'h0, 31'h0, 31'h0, 31'h0, 30'h0, 0},
    '{32'h4, 32'h5, 32'h4, 32'hffffffff, 64'hffffffff00000000, 32'h7,
      31'h0, 31'h0, 31'h0, 31'h0, 30'h0, 0},
    '{32'h4, 32'h5, 32'h6, 32'h1, 64'hffffffff00000000, 32'h8,
      31'h2aaaaaaa, 31'h55555555, 31'h2aaaaaaa, 31'h55555555, 30'h2aaaaaaa, 0},
    '{32'h7, 32'h8, 32'h9, 32'h1, 64'hffffffff00000000, 32'h9,
      31'h55555555, 31'h2aaaaaaa, 31'h15555555, 31'h2aaaaaaa, 30'h15555555, 1},
    '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 64'haaaaaaaa55555555,
      32'haaaaaaaa, 31'h0, 31'h0, 31'h0, 31'h0, 30'h0, 1}
  };

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_VERTEX_LIMIT) m_vlim = val; else m_tlim = val;
    @(posedge clk);
  endtask

  task automatic send_triangle(tri_t t);
    tri_w <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    cluster_triangle(t);
    n_words++;
  endtask

  task automatic drain();
    while (records_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic tri_t random_triangle(int unsigned span, logic [31:0] tag,
                                           logic [63:0] key);
    tri_t t;
    t.vertex_a = $urandom_range(0, span);
    t.vertex_b = $urandom_range(0, span);
    t.vertex_c = $urandom_range(0, span);
    if ($urandom_range(0, 15) == 0) t.vertex_a = $urandom;
    t.boundary_tag = tag;
    t.lod_key = key;
    t.primitive_id = $urandom;
    t.err_position = 31'($urandom_range(0, 32'h7f7fffff));
    t.err_displacement = 31'($urandom_range(0, 32'h7f7fffff));
    t.err_normal = 31'($urandom_range(0, 32'h40490fdb));
    t.err_opacity = 30'($urandom_range(0, 32'h3f800000));
    t.err_spectral = 31'($urandom_range(0, 32'h7f7fffff));
    t.end_of_mesh = ($urandom_range(0, 40) == 0);
    return t;
  endfunction

  initial begin
    tri_t t;
    rec_t r;
    logic [31:0] tag;
    logic [63:0] key;
    int unsigned span, burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      t = '{rows[i].a, rows[i].b, rows[i].c, rows[i].tag, rows[i].key, rows[i].prim,
            rows[i].e0, rows[i].e1, rows[i].e2, rows[i].e3, rows[i].e4, rows[i].eom};
      send_triangle(t);
      if (i == 0) begin
        // vertex 0 once, then the triangle, then the closing summary
        r = records_due[2];
        if (records_due.size() != 3 || r.slot_a != 1 || r.slot_b != 1 || !r.last_of_run) begin
          $error("directed row 0 prediction off");
          fails++;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    drain();

    // input backs up behind a long receiver hold-off
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 6; k++) send_triangle(random_triangle(20, 32'h9, 64'h9));
    join
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(REG_VERTEX_LIMIT, vl[ph]);
      cfg_write(REG_TRIANGLE_LIMIT, tl[ph]);
      tag = $urandom_range(0, 3);
      key = {32'($urandom_range(0, 1)), 32'($urandom_range(0, 1))};
      for (int n = 0; n < 36; n++) begin
        burst = $urandom_range(1, 8);
        span = (ph == 4 && n < 12) ? 600 : $urandom_range(3, 40);
        if ($urandom_range(0, 9) == 0) begin
          tag = $urandom;
          key = {$urandom, $urandom};
        end
        t = random_triangle(span, tag, key);
        send_triangle(t);
        if (n % burst == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    $display("%0d triangle words, %0d records, %0d cluster summaries checked",
             n_words, n_recs, n_summaries);
    $display("covered limit extremes, out-of-range limits, tag and key changes, hold-off");
    if (fails == 0 && records_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
